/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the button press classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication check: when the trigger holds, the consequence holds in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
	`ASSERT_CLK(label, (trig) |-> (cons), msg)

// Next-cycle check: when the trigger holds, the consequence holds in the following cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
	`ASSERT_CLK(label, (trig) |=> (cons), msg)

`endif

/* rtl/bpc_pkg.sv */
// Types and constants of the button press classifier.
package bpc_pkg;

	localparam int TIME_WIDTH_DEFAULT = 32;
	localparam int NOW_W = 32;
	localparam int DEBOUNCE_W = 10;
	localparam int LONG_W = 16;
	localparam int PROG_W = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 1;
	// The scaled hold time (below 2^16 times 100) and the shifted divisor.
	localparam int NUM_W = 23;
	localparam int DEN_SH_W = LONG_W + PROG_W - 1;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
	localparam logic [LONG_W-1:0] LONG_PRESS_RESET = 16'd1000;
	localparam logic [PROG_W-1:0] PROGRESS_FULL = 7'd100;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_CLICK = 2'd1,
		EV_LONG  = 2'd2
	} press_event_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEBOUNCE   = 1'b0,
		REG_LONG_PRESS = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic              button_level;
		logic [NOW_W-1:0]  now_ms;
	} sample_t;

	typedef struct packed {
		logic [1:0]        press_event;
		logic [PROG_W-1:0] hold_progress;
	} result_t;

endpackage

/* rtl/button_press_classifier_unit.sv */
// Top level of the button press classifier: debounce, click and long-press detection.
// A sample transfer passes the elapsed-time, evaluation and done states; when the hold
// progress needs it, a scaling state and the compare-subtract divider (7 quotient steps)
// come before done, and done waits while the output register is held. A new sample is
// taken only in the idle state, even while a result waits in the output register.
// Asynchronous reset releases the button, clears press state and output, reloads the times.
`include "assert_macros.svh"

module button_press_classifier_unit #(
	parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  bpc_pkg::sample_t                    sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output bpc_pkg::result_t                    result,
	input  logic                                wr_en,
	input  logic [bpc_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]      wr_data
);
	import bpc_pkg::*;

	// One-hot sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ELAP  = 6'b000010,
		ST_EVAL  = 6'b000100,
		ST_SCALE = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                  state_q;

	// Configuration registers.
	logic [DEBOUNCE_W-1:0]   debounce_q;
	logic [LONG_W-1:0]       long_press_q;

	// Button state kept between samples.
	logic                    last_level_q;
	logic [TIME_WIDTH-1:0]   press_start_q;
	logic                    pressing_q;
	logic                    long_reported_q;

	// Working registers of one sample.
	sample_t                 sample_q;
	logic [TIME_WIDTH-1:0]   elapsed_q;
	press_event_t            event_q;
	logic [LONG_W-1:0]       diff_q;
	logic [LONG_W-1:0]       den_q;
	logic [NUM_W-1:0]        rem_q;
	logic [DEN_SH_W-1:0]     div_sh_q;
	logic [2:0]              step_q;
	logic [PROG_W-1:0]       prog_q;

	// Output register.
	logic                    result_valid_q;
	result_t                 result_q;

	// Decision logic of the evaluation step.
	logic [TIME_WIDTH-1:0]   now_tw;
	logic [TIME_WIDTH-1:0]   deb_tw;
	logic [TIME_WIDTH-1:0]   long_tw;
	logic                    press_edge;
	logic [TIME_WIDTH-1:0]   el;
	logic                    pressing_n;
	logic                    long_n;
	press_event_t            event_n;
	logic                    prog_zero;
	logic                    prog_full;

	// Divider step.
	logic                    div_ge;
	logic                    out_free;

	assign now_tw  = TIME_WIDTH'(sample_q.now_ms);
	assign deb_tw  = TIME_WIDTH'(debounce_q);
	assign long_tw = TIME_WIDTH'(long_press_q);

	always_comb begin
		// A falling edge opens a press only once the debounce time has passed.
		press_edge = !sample_q.button_level && last_level_q && (elapsed_q > deb_tw);
		el         = press_edge ? '0 : elapsed_q;
		pressing_n = press_edge ? 1'b1 : pressing_q;
		long_n     = press_edge ? 1'b0 : long_reported_q;
		event_n    = EV_NONE;
		if (!sample_q.button_level && pressing_n && !long_n && (el > long_tw)) begin
			event_n = EV_LONG;
			long_n  = 1'b1;
		end
		if (sample_q.button_level && !last_level_q) begin
			if (pressing_n && !long_n && (el > deb_tw)) begin
				event_n = EV_CLICK;
			end
			pressing_n = 1'b0;
		end
		// Progress is zero outside a live press and below the debounce time, and full
		// once the hold reaches the long-press time or that time is not above debounce.
		prog_zero = !pressing_n || long_n || (el < deb_tw);
		prog_full = (long_press_q <= LONG_W'(debounce_q)) || (el >= long_tw);
	end

	// The remainder always stays below twice the shifted divisor, so one compare and
	// subtract per cycle yields one quotient bit.
	assign div_ge   = rem_q >= NUM_W'(div_sh_q);
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEBOUNCE:   debounce_q   <= wr_data[DEBOUNCE_W-1:0];
				REG_LONG_PRESS: long_press_q <= wr_data[LONG_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			last_level_q    <= 1'b1;
			press_start_q   <= '0;
			pressing_q      <= 1'b0;
			long_reported_q <= 1'b0;
			result_valid_q  <= 1'b0;
			step_q          <= '0;
		end else begin
			// In the done state the output register is reloaded instead.
			if (result_valid_q && !result_stall && (state_q != ST_DONE)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						sample_q <= sample;
						state_q  <= ST_ELAP;
					end
				end
				ST_ELAP: begin
					// Elapsed time wraps modulo the timestamp width.
					elapsed_q <= now_tw - press_start_q;
					state_q   <= ST_EVAL;
				end
				ST_EVAL: begin
					if (press_edge) begin
						press_start_q <= now_tw;
					end
					pressing_q      <= pressing_n;
					long_reported_q <= long_n;
					last_level_q    <= sample_q.button_level;
					event_q         <= event_n;
					// Below the long-press time the hold fits in the long-press width.
					diff_q          <= el[LONG_W-1:0] - LONG_W'(debounce_q);
					den_q           <= long_press_q - LONG_W'(debounce_q);
					if (prog_zero) begin
						prog_q  <= '0;
						state_q <= ST_DONE;
					end else if (prog_full) begin
						prog_q  <= PROGRESS_FULL;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					// Times 100 as 64 + 32 + 4.
					rem_q    <= (NUM_W'(diff_q) << 6) + (NUM_W'(diff_q) << 5)
						+ (NUM_W'(diff_q) << 2);
					div_sh_q <= {den_q, {(PROG_W-1){1'b0}}};
					step_q   <= 3'(PROG_W - 1);
					prog_q   <= '0;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - NUM_W'(div_sh_q);
					end
					prog_q   <= {prog_q[PROG_W-2:0], div_ge};
					div_sh_q <= div_sh_q >> 1;
					step_q   <= step_q - 3'd1;
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result_q.press_event   <= event_q;
						result_q.hold_progress <= prog_q;
						result_valid_q         <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Progress never exceeds a full hold.
	`ASSERT_IMPLIES(a_progress_range, result_valid, result.hold_progress <= PROGRESS_FULL,
		"hold progress above full")
	// A click ends the press and a long press closes it, so any event reports zero progress.
	`ASSERT_IMPLIES(a_event_zero_progress, result_valid && (result.press_event != EV_NONE),
		result.hold_progress == '0, "event reported with nonzero progress")
	// Restoring division invariant: the partial remainder stays below twice the divisor.
	`ASSERT_IMPLIES(a_div_remainder, state_q == ST_DIV, rem_q < {div_sh_q, 1'b0},
		"divider remainder out of range")
	// A sample transfer always starts the elapsed-time step.
	`ASSERT_NEXT(a_accept_starts, sample_valid && !sample_stall, state_q == ST_ELAP,
		"sample transfer did not start the sequencer")

endmodule

/* test/tb_button_press_classifier_unit.sv */
// Self-checking testbench of the button press classifier with a built-in predictor.
`timescale 1ns / 100ps

module tb_button_press_classifier_unit;
	import bpc_pkg::*;

	// The run is ended by force after this many clock cycles.
	localparam int unsigned CYCLE_LIMIT = 500000;
	// Random samples queued in each configuration phase.
	localparam int unsigned PHASE_ITEMS = 210;
	// The receiver holds off once, after this many results, for this many cycles.
	localparam int unsigned HOLDOFF_AT = 500;
	localparam int unsigned HOLDOFF_CYCLES = 400;
	// Cycles allowed for the block to settle back to idle after the last result.
	localparam int unsigned SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t button_sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t dut_result;
	logic wr_en = 1'b0;
	reg_index_t wr_index = REG_DEBOUNCE;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	button_press_classifier_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(button_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(dut_result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #1 clk = ~clk;

	// Samples waiting to be offered, and the classifications still owed by the block.
	sample_t pending_samples[$];
	result_t expected_results[$];

	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	// Set for the final phase: from then on neither side starts a new idle burst.
	bit calm = 1'b0;

	// Idle bookkeeping, index 0 for the sender and 1 for the receiver.
	int unsigned burst_left[2] = '{0, 0};
	int unsigned quiet_left[2] = '{0, 0};

	// Mirror of the block's registers and button state, at their reset values.
	logic [DEBOUNCE_W-1:0] cfg_debounce = DEBOUNCE_RESET;
	logic [LONG_W-1:0] cfg_long = LONG_PRESS_RESET;
	logic prev_level = 1'b1;
	logic [NOW_W-1:0] start_ms = '0;
	logic in_press = 1'b0;
	logic long_seen = 1'b0;

	// Timestamp at which the stimulus generator currently stands.
	logic [NOW_W-1:0] gen_now = '0;

	// Long-press completion in percent for the elapsed hold time, given the current flags.
	function automatic logic [PROG_W-1:0] hold_percent(input logic [NOW_W-1:0] held);
		logic [63:0] scaled;
		if (!in_press || long_seen || held < cfg_debounce)
			return '0;
		// A long-press time not above the debounce time leaves nothing to divide over.
		if (cfg_long <= cfg_debounce || held >= cfg_long)
			return PROGRESS_FULL;
		scaled = (64'(held) - 64'(cfg_debounce)) * 64'd100;
		return PROG_W'(scaled / (64'(cfg_long) - 64'(cfg_debounce)));
	endfunction

	// Classifies one sample and advances the mirrored button state.
	function automatic result_t classify_sample(input sample_t s);
		logic [NOW_W-1:0] held;
		press_event_t ev;
		result_t r;
		// Elapsed time since the press start wraps modulo 2^32.
		held = s.now_ms - start_ms;
		ev = EV_NONE;
		// A falling edge opens a press only once the debounce time has passed.
		if (!s.button_level && prev_level && held > cfg_debounce) begin
			start_ms = s.now_ms;
			in_press = 1'b1;
			long_seen = 1'b0;
			held = '0;
		end
		// The long press fires once per press.
		if (!s.button_level && in_press && !long_seen && held > cfg_long) begin
			ev = EV_LONG;
			long_seen = 1'b1;
		end
		// A rising edge ends the press, and is a click if it was long enough but not a long press.
		if (s.button_level && !prev_level) begin
			if (in_press && !long_seen && held > cfg_debounce)
				ev = EV_CLICK;
			in_press = 1'b0;
		end
		prev_level = s.button_level;
		r.press_event = ev;
		r.hold_progress = hold_percent(held);
		return r;
	endfunction

	// Decides whether one side idles this cycle: random bursts of idling,
	// broken up by quiet stretches in which that side never idles.
	function automatic bit take_idle(input int side);
		if (burst_left[side] > 0) begin
			burst_left[side]--;
			return 1'b1;
		end
		if (calm)
			return 1'b0;
		if (quiet_left[side] > 0) begin
			quiet_left[side]--;
			return 1'b0;
		end
		case ($urandom_range(0, 39))
			0, 1, 2, 3: begin
				burst_left[side] = $urandom_range(0, 13);
				return 1'b1;
			end
			4: quiet_left[side] = $urandom_range(30, 120);
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	// Sender: holds a stalled transfer, otherwise idles at random or offers the next sample.
	// The expected classification is computed at the edge where the transfer takes place.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				expected_results.push_back(classify_sample(button_sample));
			if (sample_valid && sample_stall) begin
				// The stalled payload stays as it is.
			end else if (pending_samples.size() == 0 || take_idle(0)) begin
				sample_valid <= 1'b0;
			end else begin
				button_sample <= pending_samples.pop_front();
				sample_valid <= 1'b1;
			end
		end
	end

	// Receiver: checks every result transfer against the oldest expectation and drives
	// the stall, including one long hold-off that lets the block fill up and stall its input.
	int unsigned holdoff_left = 0;
	bit holdoff_done = 1'b0;
	result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result event %0d progress %0d with nothing expected",
						dut_result.press_event, dut_result.hold_progress));
				end else begin
					want = expected_results.pop_front();
					if (dut_result.press_event !== want.press_event)
						report_mismatch($sformatf("press_event %0d, expected %0d (result %0d)",
							dut_result.press_event, want.press_event, results_seen));
					if (dut_result.hold_progress !== want.hold_progress)
						report_mismatch($sformatf("hold_progress %0d, expected %0d (result %0d)",
							dut_result.hold_progress, want.hold_progress, results_seen));
				end
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				result_stall <= 1'b1;
			end else if (!holdoff_done && !calm && results_seen >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= take_idle(1);
			end
		end
	end

	// Watchdog: a run that hangs or loses results ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL button_press_classifier_unit");
			$finish;
		end
	end

	task automatic push_sample(input logic level, input logic [NOW_W-1:0] stamp);
		pending_samples.push_back('{button_level: level, now_ms: stamp});
	endtask

	// Time step between samples, biased toward the debounce and long-press boundaries.
	function automatic logic [NOW_W-1:0] pick_step();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(0, cfg_debounce);
			2: return cfg_debounce + $urandom_range(0, 1);
			3: return cfg_long + $urandom_range(0, 1);
			4: return $urandom;
			default: return $urandom_range(0, cfg_long + cfg_debounce + 2);
		endcase
	endfunction

	// Offset of a hold or release sample from its press, landing on the thresholds often.
	function automatic logic [NOW_W-1:0] hold_offset();
		case ($urandom_range(0, 7))
			0: return cfg_debounce - 1 + $urandom_range(0, 2);
			1: return cfg_long - 1 + $urandom_range(0, 2);
			2: return $urandom;
			default: return $urandom_range(0, cfg_long + cfg_long / 4 + 2);
		endcase
	endfunction

	// Mostly complete presses (released samples, a press, holds, a release) with random
	// timing; the rest are single samples of random level.
	task automatic queue_presses(input int unsigned count);
		int unsigned made;
		logic [NOW_W-1:0] pressed_at;
		made = 0;
		@(negedge clk);
		while (made < count) begin
			if ($urandom_range(0, 4) == 0) begin
				gen_now += pick_step();
				push_sample(1'($urandom_range(0, 1)), gen_now);
				made++;
			end else begin
				repeat ($urandom_range(0, 2)) begin
					gen_now += pick_step();
					push_sample(1'b1, gen_now);
					made++;
				end
				gen_now += pick_step();
				pressed_at = gen_now;
				push_sample(1'b0, pressed_at);
				made++;
				repeat ($urandom_range(0, 6)) begin
					gen_now = pressed_at + hold_offset();
					push_sample(1'b0, gen_now);
					made++;
				end
				gen_now = pressed_at + hold_offset();
				push_sample(1'b1, gen_now);
				made++;
			end
		end
	endtask

	// Hand-picked samples under the reset settings: a bounce, a graded hold up to a long
	// press, a release after a long press, short and proper clicks, a press across the
	// timestamp wrap, a press rejected by debounce across the wrap, and equal timestamps.
	task automatic queue_directed();
		@(negedge clk);
		push_sample(1'b1, 32'd0);
		push_sample(1'b0, 32'd30);
		push_sample(1'b1, 32'd40);
		push_sample(1'b0, 32'd51);
		push_sample(1'b0, 32'd101);
		push_sample(1'b0, 32'd576);
		push_sample(1'b0, 32'd1051);
		push_sample(1'b0, 32'd1052);
		push_sample(1'b1, 32'd1151);
		push_sample(1'b0, 32'd2000);
		push_sample(1'b1, 32'd2050);
		push_sample(1'b0, 32'd2200);
		push_sample(1'b1, 32'd2251);
		push_sample(1'b0, 32'hFFFF_FFF0);
		push_sample(1'b0, 32'h0000_0100);
		push_sample(1'b1, 32'h0000_0200);
		push_sample(1'b1, 32'hFFFF_FFFF);
		push_sample(1'b0, 32'h0000_0000);
		push_sample(1'b0, 32'hFFFF_FFFF);
		push_sample(1'b1, 32'h7FFF_FFFF);
		push_sample(1'b0, 32'h8000_0000);
		push_sample(1'b0, 32'h8000_0000);
		push_sample(1'b1, 32'h8000_0000);
		gen_now = 32'h8000_0000;
	endtask

	// Waits until every sample has been taken and every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; the mirror follows once the write has landed.
	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_DEBOUNCE)
			cfg_debounce = value[DEBOUNCE_W-1:0];
		else
			cfg_long = value;
	endtask

	task automatic run_setting(input logic [CFG_DATA_W-1:0] debounce,
			input logic [CFG_DATA_W-1:0] long_press);
		write_reg(REG_DEBOUNCE, debounce);
		write_reg(REG_LONG_PRESS, long_press);
		queue_presses(PHASE_ITEMS);
		wait_drained();
	endtask

	int unsigned rand_debounce;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings first: directed samples, then random presses.
		queue_directed();
		wait_drained();
		queue_presses(PHASE_ITEMS);
		wait_drained();

		// Smallest legal settings, then the largest long-press time with a debounce of 1000.
		run_setting(16'd1, 16'd2);
		run_setting(16'd1000, 16'd65535);
		// A zero debounce with a zero long-press time: any nonzero elapsed time counts and
		// the progress saturates without a division.
		run_setting(16'd0, 16'd0);
		// Upper bits above the debounce field are dropped, leaving 1023 over a long press of 500.
		run_setting(16'hFFFF, 16'd500);
		rand_debounce = $urandom_range(1, 1000);
		run_setting(16'(rand_debounce), 16'($urandom_range(rand_debounce + 1, 4000)));

		// Last stretch back at the reset values, with neither side starting new idle bursts.
		calm = 1'b1;
		run_setting(16'(DEBOUNCE_RESET), LONG_PRESS_RESET);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS button_press_classifier_unit");
		else
			$display("FAIL button_press_classifier_unit");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/bpc_pkg.sv
rtl/button_press_classifier_unit.sv
test/tb_button_press_classifier_unit.sv
